// ----- rtl/ita_pkg.sv -----
package ita_pkg;

    localparam int VALUE_WIDTH = 32;

    // decimal digits of the largest magnitude, 2**(VALUE_WIDTH-1)
    function automatic int dec_digits(int w);
        longint unsigned v;
        int              n;
        v = 64'd1 << (w - 1);
        n = 0;
        do begin
            n++;
            v = v / 10;
        end while (v != 0);
        return n;
    endfunction

    localparam int DEC_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIGIT_W    = NUM_DIGITS * 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_LOWER_A = 8'd97;

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    typedef logic [VALUE_WIDTH-1:0] t_word;
    typedef logic [DIGIT_W-1:0]     t_digits;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_FIND = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

// ----- rtl/ita_if.sv -----
interface ita_in_if;
    import ita_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ----- rtl/integer_to_ascii_digits.sv -----
// Channel   Dir  Payload                        Transfer
// i_in      in   operation[0], value[31:0]      valid & ready
// o_out     out  char_out[7:0], last            valid & ready
//
// Hex: the value is loaded, the leading digit is located, then one character
// per cycle while o_out.ready is high. Decimal: shift/add-3 steps in the BCD
// converter, the leading digit is located, then one character per cycle as for
// hex. i_in.ready is high only while no number is in work.
// Reset is synchronous, active low, and empties the output register.
module integer_to_ascii_digits (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ita_in_if.sink     i_in,
    ita_out_if.source  o_out
);
    import ita_pkg::*;

    t_state     r_state, n_state;
    t_digits    r_bcd, n_bcd;
    t_word      r_bin, n_bin;
    t_cnt       r_cnt, n_cnt;
    t_idx       r_idx, n_idx;
    logic       r_neg, n_neg;
    logic       r_ovld, n_ovld;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;

    t_word      in_word;
    t_word      in_mag;
    logic       in_neg;
    t_digits    bcd_adj;
    t_idx       lead_idx;
    logic [3:0] cur_dig;
    logic [7:0] dig_char;

    assign in_word = t_word'(i_in.value);
    assign in_neg  = (i_in.operation == OP_DEC) && in_word[VALUE_WIDTH-1];
    // most negative value negates onto itself, which is the right magnitude unsigned
    assign in_mag  = in_neg ? t_word'(~in_word + 1'b1) : in_word;

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    // highest nonzero digit; zero gives index 0 so a single '0' comes out
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                lead_idx = t_idx'(i);
            end
        end
    end

    assign cur_dig  = r_bcd[r_idx*4 +: 4];
    assign dig_char = (cur_dig < 4'd10) ? CH_ZERO + {4'd0, cur_dig}
                                        : CH_LOWER_A + {4'd0, cur_dig} - 8'd10;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovld;
    assign o_out.char_out = r_char;
    assign o_out.last     = r_last;

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_ovld  = r_ovld;
        n_char  = r_char;
        n_last  = r_last;

        if (r_ovld && o_out.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_neg = in_neg;
                    if (i_in.operation == OP_HEX) begin
                        n_bcd   = DIGIT_W'(in_word);
                        n_state = S_FIND;
                    end else begin
                        n_bcd   = '0;
                        n_bin   = in_mag;
                        n_cnt   = CNT_W'(VALUE_WIDTH - 1);
                        n_state = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[DIGIT_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_FIND;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIND: begin
                n_idx   = lead_idx;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld = 1'b1;
                    if (r_neg) begin
                        n_char = CH_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = dig_char;
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

// ----- rtl/ita_chk.sv -----
module ita_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);
    import ita_pkg::*;

    // one number at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while previous number in work");

    // a pending non-final character means the number is still in work
    a_busy_mid_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("ready while number only partly delivered");

    // the sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char == CH_MINUS) |-> !i_out_last)
        else $error("minus sign flagged as last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
                                        && $stable(i_out_last))
        else $error("stalled output changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind integer_to_ascii_digits ita_chk u_ita_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_out),
    .i_out_last  (o_out.last)
);

// ----- dv/ita_checker.sv -----
module ita_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ita_in_if    i_in,
    ita_out_if   i_result,
    output int   o_fail_count,
    output int   o_pending
);
    import ita_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    t_char_exp char_queue[$];
    int        errors = 0;

    assign o_fail_count = errors;

    // Expected characters of one number, most significant first.
    function automatic void queue_digits(input logic op, input t_word word);
        logic [VALUE_WIDTH:0] mag;
        logic [VALUE_WIDTH:0] base;
        logic [VALUE_WIDTH:0] rem;
        logic [7:0]           rev[$];
        logic [7:0]           ch;
        logic                 neg;
        neg  = (op == OP_DEC) && word[VALUE_WIDTH-1];
        base = (op == OP_HEX) ? (VALUE_WIDTH+1)'(16) : (VALUE_WIDTH+1)'(10);
        // one extra bit keeps the magnitude of the most negative value
        mag  = neg ? ({1'b0, ~word} + 1'b1) : {1'b0, word};
        do begin
            rem = mag % base;
            if (rem < 10) begin
                ch = CH_ZERO + 8'(rem);
            end else begin
                ch = CH_LOWER_A + 8'(rem - 10);
            end
            rev.push_back(ch);
            mag = mag / base;
        end while (mag != 0);
        if (neg) begin
            char_queue.push_back('{ch: CH_MINUS, last: 1'b0});
        end
        while (rev.size() > 0) begin
            ch = rev.pop_back();
            char_queue.push_back('{ch: ch, last: (rev.size() == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_exp want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                queue_digits(i_in.operation, t_word'(i_in.value));
            end
            if (i_result.valid && i_result.ready) begin
                if (char_queue.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                             $time, i_result.char_out, i_result.last);
                    errors++;
                end else begin
                    want = char_queue.pop_front();
                    if (want.ch !== i_result.char_out) begin
                        $display("%0t: char_out mismatch, expected %h, actual %h",
                                 $time, want.ch, i_result.char_out);
                        errors++;
                    end
                    if (want.last !== i_result.last) begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, i_result.last);
                        errors++;
                    end
                end
            end
        end
        o_pending <= char_queue.size();
    end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    import ita_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic no_idle = 1'b0;
    int   fail_count;
    int   pending;

    ita_in_if  in_ch ();
    ita_out_if out_ch ();

    integer_to_ascii_digits DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ita_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one number; returns at the edge of its transfer.
    task automatic send_number(input logic op, input t_word val);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(15);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= val;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_word pick_value();
        t_word       v;
        int unsigned k;
        case ($urandom_range(5))
            0: v = $urandom;
            1: begin
                v = $urandom_range(20);
                if ($urandom_range(1)) v = -v;
            end
            2: begin
                // around a power of ten
                v = 1;
                k = $urandom_range(9);
                repeat (k) v = v * 10;
                v = v + $urandom_range(2) - 1;
                if ($urandom_range(1)) v = -v;
            end
            3: begin
                k = $urandom_range(7);
                v = (t_word'(1) << (4 * k)) + $urandom_range(2) - 1;
            end
            4: begin
                if ($urandom_range(1)) v = 32'h8000_0000 + $urandom_range(3);
                else                   v = 32'h7fff_ffff - $urandom_range(3);
            end
            default: v = $urandom >> $urandom_range(31);
        endcase
        return v;
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_number(logic'($urandom_range(1)), pick_value());
    endtask

    // receive side: per-result stall, plus two long hold-offs
    initial begin
        int unsigned gap;
        int unsigned taken;
        out_ch.ready <= 1'b0;
        taken = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == 150 || taken == 2000) begin
                out_ch.ready <= 1'b0;
                for (int c = 0; c < 400; c++) @(posedge i_clk);
            end
            gap = no_idle ? 0 : $urandom_range(15);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_DEC;
        in_ch.value     <= '0;
        i_rst_n         <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, extremes, sign handling and digit boundaries
        send_number(OP_DEC, 32'd0);
        send_number(OP_HEX, 32'd0);
        send_number(OP_DEC, 32'd1);
        send_number(OP_DEC, 32'hffff_ffff);
        send_number(OP_HEX, 32'hffff_ffff);
        send_number(OP_DEC, 32'h8000_0000);
        send_number(OP_HEX, 32'h8000_0000);
        send_number(OP_DEC, 32'h7fff_ffff);
        send_number(OP_HEX, 32'h7fff_ffff);
        send_number(OP_DEC, 32'd9);
        send_number(OP_DEC, 32'd10);
        send_number(OP_HEX, 32'd15);
        send_number(OP_HEX, 32'd16);
        send_number(OP_DEC, 32'd99);
        send_number(OP_DEC, 32'd100);
        send_number(OP_DEC, -32'sd10);
        send_number(OP_HEX, -32'sd10);
        send_number(OP_HEX, 32'h1000_0000);
        send_number(OP_DEC, 32'd1_000_000_000);
        send_number(OP_DEC, -32'sd1_000_000_000);
        send_number(OP_HEX, 32'habcd_ef01);
        send_number(OP_HEX, 32'h5555_aaaa);
        drain();

        send_random(200);
        no_idle = 1'b1;
        send_random(80);
        no_idle = 1'b0;
        drain();
        send_random(150);
        drain();

        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- integer_to_ascii_digits.f -----
rtl/ita_pkg.sv
rtl/ita_if.sv
rtl/integer_to_ascii_digits.sv
rtl/ita_chk.sv
dv/ita_checker.sv
dv/tb_top.sv
